### sv/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types, codes and helpers of the delta list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_RES       = 16;
    localparam int NW            = $clog2(MAX_RES);

    // request operation codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_ARM   = 2'd1;
    localparam logic [1:0] FUNC_DEL   = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_FIRED   = 2'd0;
    localparam logic [1:0] KIND_QUERY   = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_NOTPEND = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         event_id;
        logic signed [31:0] delay_ticks;
        logic signed [31:0] arg_value;
        logic [15:0]        elapsed;
    } dltq_in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         fired_id;
        logic signed [31:0] fired_arg;
        logic signed [31:0] remaining;
        logic               last;
    } dltq_out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE,
        ST_T_RD, ST_T_LD, ST_T_EVAL, ST_T_RD2, ST_T_LD2, ST_T_EMIT,
        ST_S_RD, ST_S_LD,
        ST_U_RD, ST_U_LD, ST_U_RD2, ST_U_LD2, ST_POST_UNL,
        ST_I_RD, ST_I_LD, ST_I_LINK, ST_I_LINK2,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_WALK_SPAN, OP_WALK_INS, OP_WALK_UNL,
        OP_T_LD, OP_T_FIRE, OP_T_LD2, OP_S_LD, OP_U_LD, OP_U_LD2,
        OP_I_LD, OP_I_LINK, OP_I_LINK2
    } dp_op_t;

    typedef enum logic [2:0] {
        EM_FIRE, EM_ACC, EM_ARM_NOW, EM_ARM_DONE, EM_BAD
    } emit_sel_t;

    typedef struct packed {
        dp_op_t     op;
        logic       emit;
        emit_sel_t  sel;
        logic [1:0] kind;
    } dltq_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       id_bad;
        logic       id_pending;
        logic       cur_vld;
        logic       cur_is_id;
        logic       q_next_vld;
        logic       c_nx_vld;
        logic       c_d_pos;
        logic       delta_le_d;
        logic       delay_pos;
        logic       f_last;
        logic       out_free;
    } dltq_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh07fffffff) begin
            return 32'sh7fffffff;
        end else if (v < 34'sh380000000) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

### sv/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer of the timer queue: walks the list one entry per read/load pair.
// ----------------------------------------------------------------------------
module dltq_ctrl import dltq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dltq_sts_t sts,
    output dltq_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    emit_sel_t   sel_reg, sel_next;
    logic [1:0]  kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= EM_BAD;
            kind_reg  <= KIND_DONE;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        kind_next  = kind_reg;
        s_ready    = 1'b0;
        cmd.op     = OP_NONE;
        cmd.emit   = 1'b0;
        cmd.sel    = sel_reg;
        cmd.kind   = kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // no request is taken while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.func == FUNC_TICK) begin
                    cmd.op     = OP_WALK_SPAN;
                    state_next = ST_T_RD;
                end else if (sts.id_bad) begin
                    sel_next   = EM_BAD;
                    state_next = ST_EMIT;
                end else if (sts.id_pending && sts.func != FUNC_QUERY) begin
                    cmd.op     = OP_WALK_UNL;
                    state_next = ST_U_RD;
                end else if (sts.func == FUNC_ARM) begin
                    if (sts.delay_pos) begin
                        cmd.op     = OP_WALK_INS;
                        state_next = ST_I_RD;
                    end else begin
                        sel_next   = EM_ARM_NOW;
                        state_next = ST_EMIT;
                    end
                end else begin
                    cmd.op     = OP_WALK_SPAN;
                    kind_next  = (sts.func == FUNC_QUERY && sts.id_pending) ?
                                 KIND_QUERY : KIND_NOTPEND;
                    state_next = ST_S_RD;
                end
            end
            ST_T_RD: state_next = ST_T_LD;
            ST_T_LD: begin
                if (!sts.cur_vld) begin
                    sel_next   = EM_ACC;
                    kind_next  = KIND_DONE;
                    state_next = ST_EMIT;
                end else begin
                    cmd.op     = OP_T_LD;
                    state_next = ST_T_EVAL;
                end
            end
            ST_T_EVAL: begin
                if (sts.c_d_pos) begin
                    cmd.op     = OP_WALK_SPAN;
                    kind_next  = KIND_DONE;
                    state_next = ST_S_RD;
                end else begin
                    cmd.op     = OP_T_FIRE;
                    state_next = sts.c_nx_vld ? ST_T_RD2 : ST_T_EMIT;
                end
            end
            ST_T_RD2: state_next = ST_T_LD2;
            ST_T_LD2: begin
                cmd.op     = OP_T_LD2;
                state_next = ST_T_EMIT;
            end
            ST_T_EMIT: begin
                cmd.sel = EM_FIRE;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.f_last ? ST_IDLE : ST_T_EVAL;
                end
            end
            ST_S_RD: state_next = ST_S_LD;
            ST_S_LD: begin
                if (!sts.cur_vld) begin
                    sel_next   = EM_ACC;
                    state_next = ST_EMIT;
                end else begin
                    cmd.op = OP_S_LD;
                    if (kind_reg == KIND_QUERY && sts.cur_is_id) begin
                        sel_next   = EM_ACC;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_S_RD;
                    end
                end
            end
            ST_U_RD: state_next = ST_U_LD;
            ST_U_LD: begin
                cmd.op = OP_U_LD;
                if (sts.cur_is_id) begin
                    state_next = sts.q_next_vld ? ST_U_RD2 : ST_POST_UNL;
                end else begin
                    state_next = ST_U_RD;
                end
            end
            ST_U_RD2: state_next = ST_U_LD2;
            ST_U_LD2: begin
                cmd.op     = OP_U_LD2;
                state_next = ST_POST_UNL;
            end
            ST_POST_UNL: begin
                if (sts.func == FUNC_ARM) begin
                    if (sts.delay_pos) begin
                        cmd.op     = OP_WALK_INS;
                        state_next = ST_I_RD;
                    end else begin
                        sel_next   = EM_ARM_NOW;
                        state_next = ST_EMIT;
                    end
                end else begin
                    cmd.op     = OP_WALK_SPAN;
                    kind_next  = KIND_DONE;
                    state_next = ST_S_RD;
                end
            end
            ST_I_RD: state_next = ST_I_LD;
            ST_I_LD: begin
                if (!sts.cur_vld) begin
                    state_next = ST_I_LINK;
                end else begin
                    cmd.op     = OP_I_LD;
                    state_next = sts.delta_le_d ? ST_I_RD : ST_I_LINK;
                end
            end
            ST_I_LINK: begin
                cmd.op     = OP_I_LINK;
                state_next = ST_I_LINK2;
            end
            ST_I_LINK2: begin
                cmd.op     = OP_I_LINK2;
                sel_next   = EM_ARM_DONE;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### sv/dltq_dp.sv
// ----------------------------------------------------------------------------
// dltq_dp
// Datapath: slot memories, list pointers, accumulators and output register.
// ----------------------------------------------------------------------------
module dltq_dp import dltq_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  dltq_in_t  s_data,
    input  logic      m_ready,
    output logic      m_valid,
    output dltq_out_t m_data,
    input  dltq_cmd_t cmd,
    output dltq_sts_t sts
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int AW = IW + 34;
    localparam logic signed [AW:0] MAXW = (AW+1)'(64'sd2147483647);
    localparam logic signed [AW:0] MINW = (AW+1)'(-64'sd2147483648);

    typedef struct packed {
        logic          vld;
        logic [IW-1:0] idx;
    } link_t;

    function automatic logic signed [31:0] satw(input logic signed [AW:0] v);
        if (v > MAXW) begin
            return 32'sh7fffffff;
        end else if (v < MINW) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // slot stores
    logic signed [31:0] delta_mem [NUM_SLOTS];
    logic signed [31:0] arg_mem   [NUM_SLOTS];
    link_t              next_mem  [NUM_SLOTS];
    logic signed [31:0] q_delta, q_arg;
    link_t              q_next;

    dltq_in_t           item_reg;
    link_t              head_reg, cur_reg, prev_reg, c_nx_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [31:0] c_d_reg, c_arg_reg, f_arg_reg, f_d_reg, dcur_reg;
    logic [IW-1:0]      f_id_reg;
    logic               f_last_reg;
    logic [NW-1:0]      n_reg;
    logic [NUM_SLOTS-1:0] pend_reg;
    dltq_out_t          out_reg;
    logic               m_valid_reg;

    logic [8:0]         id_ext, s_id_ext;
    logic [IW-1:0]      id_idx;
    logic               id_bad, s_id_bad, out_free, cur_is_id, le;
    logic signed [33:0] el34;
    logic signed [31:0] t_sub, t_add, u_add, i_sub;
    logic signed [AW:0] acc_w, q_d_w, acc_sum, acc_dif;
    logic               delta_we, next_we;
    logic [IW-1:0]      delta_wa, next_wa;
    logic signed [31:0] delta_wd;
    link_t              next_wd;
    dltq_out_t          em_data;

    assign id_ext    = {5'd0, item_reg.event_id};
    assign s_id_ext  = {5'd0, s_data.event_id};
    assign id_bad    = id_ext >= 9'(NUM_SLOTS);
    assign s_id_bad  = s_id_ext >= 9'(NUM_SLOTS);
    assign id_idx    = id_ext[IW-1:0];
    assign cur_is_id = cur_reg.idx == id_idx;
    assign out_free  = !m_valid_reg || m_ready;

    assign el34    = signed'(34'({1'b0, item_reg.elapsed}));
    assign t_sub   = sat32(34'(q_delta) - el34);
    assign t_add   = sat32(34'(q_delta) + 34'(c_d_reg));
    assign u_add   = sat32(34'(q_delta) + 34'(dcur_reg));
    assign acc_w   = (AW+1)'(acc_reg);
    assign q_d_w   = (AW+1)'(q_delta);
    assign acc_sum = acc_w + q_d_w;
    assign acc_dif = acc_w - q_d_w;
    assign le      = q_d_w <= acc_w;
    assign i_sub   = satw(q_d_w - acc_w);

    // store write ports
    always_comb begin
        delta_we = 1'b0;
        delta_wa = cur_reg.idx;
        delta_wd = t_sub;
        next_we  = 1'b0;
        next_wa  = prev_reg.idx;
        next_wd  = q_next;
        unique case (cmd.op)
            OP_T_LD:  delta_we = 1'b1;
            OP_T_LD2: begin
                delta_we = 1'b1;
                delta_wd = t_add;
            end
            OP_U_LD:  next_we = cur_is_id && prev_reg.vld;
            OP_U_LD2: begin
                delta_we = 1'b1;
                delta_wd = u_add;
            end
            OP_I_LD: begin
                delta_we = !le;
                delta_wd = i_sub;
            end
            OP_I_LINK: begin
                delta_we = 1'b1;
                delta_wa = id_idx;
                delta_wd = satw(acc_w);
                next_we  = 1'b1;
                next_wa  = id_idx;
                next_wd  = cur_reg;
            end
            OP_I_LINK2: begin
                next_we = prev_reg.vld;
                next_wd = '{vld: 1'b1, idx: id_idx};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (delta_we) begin
            delta_mem[delta_wa] <= delta_wd;
        end
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (cmd.op == OP_ACCEPT && s_data.func == FUNC_ARM && !s_id_bad) begin
            arg_mem[s_id_ext[IW-1:0]] <= s_data.arg_value;
        end
        q_delta <= delta_mem[cur_reg.idx];
        q_arg   <= arg_mem[cur_reg.idx];
        q_next  <= next_mem[cur_reg.idx];
    end

    // result formatting
    always_comb begin
        em_data = '{kind: KIND_NOTPEND, fired_id: item_reg.event_id, fired_arg: '0,
                    remaining: '0, last: 1'b1};
        case (cmd.sel)
            EM_FIRE: begin
                em_data.kind      = KIND_FIRED;
                em_data.fired_id  = 4'(f_id_reg);
                em_data.fired_arg = f_arg_reg;
                em_data.remaining = f_d_reg;
                em_data.last      = f_last_reg;
            end
            EM_ACC: begin
                em_data.kind      = cmd.kind;
                em_data.remaining = satw(acc_w);
                if (item_reg.func == FUNC_TICK) begin
                    em_data.fired_id = '0;
                end
            end
            EM_ARM_NOW: begin
                em_data.kind      = KIND_FIRED;
                em_data.fired_arg = item_reg.arg_value;
                em_data.remaining = item_reg.delay_ticks;
            end
            EM_ARM_DONE: begin
                em_data.kind      = KIND_DONE;
                em_data.remaining = item_reg.delay_ticks;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_T_FIRE: begin
                    pend_reg[cur_reg.idx] <= 1'b0;
                    head_reg              <= c_nx_reg;
                end
                OP_U_LD: begin
                    if (cur_is_id) begin
                        pend_reg[id_idx] <= 1'b0;
                        if (!prev_reg.vld) begin
                            head_reg <= q_next;
                        end
                    end
                end
                OP_I_LINK: begin
                    pend_reg[id_idx] <= 1'b1;
                    if (!prev_reg.vld) begin
                        head_reg <= '{vld: 1'b1, idx: id_idx};
                    end
                end
                default: ;
            endcase
        end
    end

    // walk registers
    always_ff @(posedge aclk) begin
        if (cmd.emit && out_free) begin
            out_reg <= em_data;
            if (cmd.sel == EM_FIRE) begin
                n_reg <= n_reg + 1'b1;
            end
        end
        unique case (cmd.op)
            OP_ACCEPT: begin
                item_reg <= s_data;
                n_reg    <= '0;
            end
            OP_WALK_SPAN: begin
                cur_reg <= head_reg;
                acc_reg <= '0;
            end
            OP_WALK_INS: begin
                cur_reg  <= head_reg;
                prev_reg <= '0;
                acc_reg  <= AW'(item_reg.delay_ticks);
            end
            OP_WALK_UNL: begin
                cur_reg  <= head_reg;
                prev_reg <= '0;
            end
            OP_T_LD: begin
                c_d_reg   <= t_sub;
                c_arg_reg <= q_arg;
                c_nx_reg  <= q_next;
            end
            OP_T_FIRE: begin
                f_id_reg   <= cur_reg.idx;
                f_arg_reg  <= c_arg_reg;
                f_d_reg    <= c_d_reg;
                f_last_reg <= !c_nx_reg.vld;
                cur_reg    <= c_nx_reg;
            end
            OP_T_LD2: begin
                c_d_reg    <= t_add;
                c_arg_reg  <= q_arg;
                c_nx_reg   <= q_next;
                f_last_reg <= (n_reg == NW'(MAX_RES - 1)) || (t_add > 0);
            end
            OP_S_LD: begin
                acc_reg <= acc_sum[AW-1:0];
                cur_reg <= q_next;
            end
            OP_U_LD: begin
                if (cur_is_id) begin
                    dcur_reg <= q_delta;
                end else begin
                    prev_reg <= cur_reg;
                end
                cur_reg <= q_next;
            end
            OP_I_LD: begin
                if (le) begin
                    acc_reg  <= acc_dif[AW-1:0];
                    prev_reg <= cur_reg;
                    cur_reg  <= q_next;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign sts.func       = item_reg.func;
    assign sts.id_bad     = id_bad;
    assign sts.id_pending = !id_bad && pend_reg[id_idx];
    assign sts.cur_vld    = cur_reg.vld;
    assign sts.cur_is_id  = cur_is_id;
    assign sts.q_next_vld = q_next.vld;
    assign sts.c_nx_vld   = c_nx_reg.vld;
    assign sts.c_d_pos    = c_d_reg > 0;
    assign sts.delta_le_d = le;
    assign sts.delay_pos  = item_reg.delay_ticks > 0;
    assign sts.f_last     = f_last_reg;
    assign sts.out_free   = out_free;

endmodule

### sv/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Timer queue of NUM_SLOTS slots kept as a deadline-ordered delta list.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carries one request (dltq_in_t): tick, arm,
//   delete or query. m_valid/m_ready/m_data returns results (dltq_out_t);
//   the final result of a request has last set.
//   A tick returns one fired result per expired slot (up to 16), or one
//   done result carrying the total queue span.
// Operation:
//   Requests are handled one at a time. Every list walk reads the slot
//   stores through one registered port, so each visited entry takes a
//   read state and a load state.
// Reset:
//   Clears the pending flags and empties the list; slot stores keep stale
//   data that is never read before it is written.
// Stalls:
//   A result waits in the output register while m_ready is low; the walk
//   holds, and a new request is taken once the previous last result is
//   registered.
// ----------------------------------------------------------------------------
module delta_list_timer_queue import dltq_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dltq_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output dltq_out_t m_data
);

    dltq_cmd_t cmd;
    dltq_sts_t sts;

    // sequencer: one list entry per read/load state pair
    dltq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // slot stores, list pointers and the result register
    dltq_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

    // an accepted request moves the sequencer to its decode state, where s_ready is low
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken in back-to-back cycles");

    // a non-final result only ever waits while the tick walk is still running
    a_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> !s_ready)
        else $error("new request accepted before the last result");

    // a fired event is never early
    a_fire_due: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_FIRED) |-> (m_data.remaining <= 0))
        else $error("event fired with time still remaining");

endmodule

### test/delta_list_timer_queue_test.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_test
// Drives directed and random tick, arm, delete and query requests into the timer queue,
// mirrors the delta list in a local predictor and checks every result.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_test import dltq_pkg::*;;

    localparam int NSLOT    = 16;
    localparam int NIL      = NSLOT;
    localparam int WDOG_MAX = 20000;

    // Holds the expected results in order and compares the returned ones.
    class timer_scoreboard;
        dltq_out_t expected_q[$];
        int        mismatches;

        function void note_request(dltq_out_t res[$]);
            foreach (res[i]) expected_q.push_back(res[i]);
        endfunction

        function void check_result(dltq_out_t got);
            dltq_out_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: kind %0d/%0d id %0d/%0d arg %0d/%0d rem %0d/%0d last %0b/%0b",
                             want.kind, got.kind, want.fired_id, got.fired_id,
                             want.fired_arg, got.fired_arg, want.remaining, got.remaining,
                             want.last, got.last);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    dltq_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    dltq_out_t m_data;

    timer_scoreboard sb;
    int  idle_cycles;
    int  stall_mode;

    // predictor copy of the delta list
    logic signed [31:0] q_delta[NSLOT];
    logic signed [31:0] q_arg[NSLOT];
    int                 q_next[NSLOT];
    bit                 q_pend[NSLOT];
    int                 q_head;

    delta_list_timer_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint list_span();
        longint s;
        int     cur;
        s   = 0;
        cur = q_head;
        for (int i = 0; i < NSLOT && cur < NSLOT; i++) begin
            s   += q_delta[cur];
            cur  = q_next[cur];
        end
        return s;
    endfunction

    function automatic void unlink(int id);
        int prv, cur, nx;
        prv = NIL;
        cur = q_head;
        for (int i = 0; i < NSLOT && cur < NSLOT; i++) begin
            if (cur == id) begin
                nx = q_next[cur];
                if (prv == NIL) q_head = nx;
                else q_next[prv] = nx;
                if (nx < NSLOT) q_delta[nx] = clamp32(longint'(q_delta[nx]) + q_delta[cur]);
                break;
            end
            prv = cur;
            cur = q_next[cur];
        end
        q_pend[id] = 0;
    endfunction

    function automatic void link_sorted(int id, longint d);
        int prv, cur;
        prv = NIL;
        cur = q_head;
        for (int i = 0; i < NSLOT && cur < NSLOT; i++) begin
            if (longint'(q_delta[cur]) <= d) begin
                d   -= q_delta[cur];
                prv  = cur;
                cur  = q_next[cur];
            end else begin
                q_delta[cur] = clamp32(longint'(q_delta[cur]) - d);
                break;
            end
        end
        if (cur >= NSLOT) cur = NIL;
        q_next[id] = cur;
        if (prv == NIL) q_head = id;
        else q_next[prv] = id;
        q_delta[id] = clamp32(d);
        q_pend[id]  = 1;
    endfunction

    function automatic dltq_out_t mk(logic [1:0] k, int id, logic signed [31:0] a, longint r);
        dltq_out_t o;
        o.kind      = k;
        o.fired_id  = id[3:0];
        o.fired_arg = a;
        o.remaining = clamp32(r);
        o.last      = 1'b0;
        return o;
    endfunction

    // Updates the list for one request and returns the results it causes.
    function automatic void timer_predict(dltq_in_t rq, ref dltq_out_t res[$]);
        int     id, h;
        longint s, dly;
        int     cur;
        id  = rq.event_id;
        dly = rq.delay_ticks;
        res.delete();
        if (rq.func == FUNC_TICK) begin
            if (q_head < NSLOT)
                q_delta[q_head] = clamp32(longint'(q_delta[q_head]) - rq.elapsed);
            while (res.size() < MAX_RES && q_head < NSLOT && q_delta[q_head] <= 0) begin
                h      = q_head;
                q_head = q_next[h];
                if (q_head < NSLOT)
                    q_delta[q_head] = clamp32(longint'(q_delta[q_head]) + q_delta[h]);
                q_pend[h] = 0;
                res.push_back(mk(KIND_FIRED, h, q_arg[h], q_delta[h]));
            end
            if (res.size() == 0) res.push_back(mk(KIND_DONE, 0, 0, list_span()));
        end else if (rq.func == FUNC_ARM) begin
            if (q_pend[id]) unlink(id);
            q_arg[id] = rq.arg_value;
            if (dly <= 0) res.push_back(mk(KIND_FIRED, id, rq.arg_value, dly));
            else begin
                link_sorted(id, dly);
                res.push_back(mk(KIND_DONE, id, 0, dly));
            end
        end else if (rq.func == FUNC_DEL) begin
            if (q_pend[id]) begin
                unlink(id);
                res.push_back(mk(KIND_DONE, id, 0, list_span()));
            end else res.push_back(mk(KIND_NOTPEND, id, 0, list_span()));
        end else begin
            if (q_pend[id]) begin
                s   = 0;
                cur = q_head;
                for (int i = 0; i < NSLOT && cur < NSLOT; i++) begin
                    s += q_delta[cur];
                    if (cur == id) break;
                    cur = q_next[cur];
                end
                res.push_back(mk(KIND_QUERY, id, 0, s));
            end else res.push_back(mk(KIND_NOTPEND, id, 0, list_span()));
        end
        res[res.size()-1].last = 1'b1;
    endfunction

    // Receiver: stall pattern changes every so often, with clean stretches.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(3) != 0);
                default: m_ready <= ($urandom_range(3) == 0);
            endcase
            if ($urandom_range(63) == 0) stall_mode <= $urandom_range(2);
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("delta_list_timer_queue verification failed");
                $finish;
            end
        end
    end

    int burst_left;

    // Sends one request; valid stays up within a burst and drops during a gap.
    task automatic send_request(dltq_in_t rq);
        dltq_out_t res[$];
        int        gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
        end
        burst_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
        timer_predict(rq, res);
        sb.note_request(res);
    endtask

    function automatic dltq_in_t make_req(logic [1:0] f, int id, longint dly, longint a,
                                          int el);
        dltq_in_t rq;
        rq.func        = f;
        rq.event_id    = id[3:0];
        rq.delay_ticks = dly[31:0];
        rq.arg_value   = a[31:0];
        rq.elapsed     = el[15:0];
        return rq;
    endfunction

    function automatic longint rand_delay();
        case ($urandom_range(9))
            0:       return $signed($urandom());
            1:       return -longint'($urandom_range(5));
            2:       return 64'sd2147483647 - $urandom_range(3);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    initial begin
        dltq_in_t rq;
        sb          = new();
        idle_cycles = 0;
        stall_mode  = 0;
        burst_left  = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        foreach (q_pend[i]) q_pend[i] = 0;
        q_head = NIL;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty tick, bad-free queries, extremes, saturation, firing a full queue
        send_request(make_req(FUNC_TICK, 0, 0, 0, 16'hffff));
        send_request(make_req(FUNC_QUERY, 5, 0, 0, 0));
        send_request(make_req(FUNC_DEL, 5, 0, 0, 0));
        send_request(make_req(FUNC_ARM, 0, 0, 32'sh7fffffff, 0));
        send_request(make_req(FUNC_ARM, 1, -64'sd2147483648, -64'sd2147483648, 0));
        send_request(make_req(FUNC_ARM, 2, 64'sd2147483647, -1, 0));
        send_request(make_req(FUNC_ARM, 3, 64'sd2147483647, 7, 0));
        send_request(make_req(FUNC_QUERY, 3, 0, 0, 0));
        send_request(make_req(FUNC_ARM, 4, 10, 4, 0));
        send_request(make_req(FUNC_ARM, 4, 10, 44, 0));
        send_request(make_req(FUNC_TICK, 0, 0, 0, 3));
        send_request(make_req(FUNC_DEL, 2, 0, 0, 0));
        send_request(make_req(FUNC_DEL, 4, 0, 0, 0));
        send_request(make_req(FUNC_DEL, 3, 0, 0, 0));
        for (int i = 0; i < NSLOT; i++)
            send_request(make_req(FUNC_ARM, i, 1 + (i % 2), i * 3, 0));
        send_request(make_req(FUNC_TICK, 0, 0, 0, 1));
        send_request(make_req(FUNC_TICK, 0, 0, 0, 16'hffff));

        // random: mostly arms and ticks so the list fills and drains
        for (int n = 0; n < 450; n++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: rq = make_req(FUNC_ARM, $urandom_range(15), rand_delay(),
                                          $signed($urandom()), $urandom_range(65535));
                4, 5:       rq = make_req(FUNC_TICK, $urandom_range(15), $signed($urandom()),
                                          $signed($urandom()),
                                          ($urandom_range(7) == 0) ? $urandom_range(65535)
                                                                   : $urandom_range(80));
                6, 7:       rq = make_req(FUNC_QUERY, $urandom_range(15), $signed($urandom()),
                                          $signed($urandom()), $urandom_range(65535));
                default:    rq = make_req(FUNC_DEL, $urandom_range(15), $signed($urandom()),
                                          $signed($urandom()), $urandom_range(65535));
            endcase
            send_request(rq);
        end
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("delta_list_timer_queue verification clean");
        end else begin
            $display("delta_list_timer_queue verification failed");
        end
        $finish;
    end

endmodule
